// ===== hdl/lte_pkg.sv =====
// Package for the location table engine: status codes, commands, constants.
// No dependencies.
package lte_pkg;
  localparam int unsigned TableDepth = 64;

  localparam logic [1:0] CmdAddPv     = 2'd0;
  localparam logic [1:0] CmdAddBeacon = 2'd1;
  localparam logic [1:0] CmdAgeOut    = 2'd2;
  localparam logic [1:0] CmdLookup    = 2'd3;

  localparam logic [2:0] StInserted  = 3'd0;
  localparam logic [2:0] StUpdated   = 3'd1;
  localparam logic [2:0] StDuplicate = 3'd2;
  localparam logic [2:0] StFull      = 3'd3;
  localparam logic [2:0] StAged      = 3'd4;
  localparam logic [2:0] StFound     = 3'd5;
  localparam logic [2:0] StMissing   = 3'd6;

  localparam logic [0:0] CfgOwnAddress = 1'd0;
  localparam logic [0:0] CfgLifetime   = 1'd1;

  localparam logic [15:0] LifetimeReset = 16'd5;
endpackage

// ===== hdl/location_table_engine.sv =====
// Location table engine top level: table memories, scan sequencer, result register.
// Depends on lte_pkg.
//
//  channel   | valid     | stall     | payload
//  request   | valid     | stall     | command .. current_time
//  result    | out_valid | out_stall | status .. entry_accuracies
//  config    | cfg_write | -         | cfg_index, cfg_data
//
// A request goes through the accepting state, one pass over the table at one
// entry per cycle, a last state for the registered read of the last entry, then
// a write-back state that writes the entry found or the free slot chosen.
// Entry valid and neighbour bits sit in flip-flops cleared by reset; no clearing pass.
// A result waits in the output register while stalled; the next request is
// accepted as soon as that register is free or is being emptied.
module location_table_engine #(
  parameter int unsigned TABLE_DEPTH = lte_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [31:0] timestamp,
  input  logic [31:0] latitude,
  input  logic [31:0] longitude,
  input  logic [15:0] altitude,
  input  logic [15:0] speed,
  input  logic [15:0] heading,
  input  logic [31:0] accuracies,
  input  logic [31:0] current_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        is_neighbour,
  output logic [6:0]  neighbour_count,
  output logic [31:0] entry_timestamp,
  output logic [31:0] entry_latitude,
  output logic [31:0] entry_longitude,
  output logic [15:0] entry_altitude,
  output logic [15:0] entry_speed,
  output logic [15:0] entry_heading,
  output logic [31:0] entry_accuracies
);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LAST  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [31:0] own_address;
  logic [15:0] entry_lifetime;

  logic [TABLE_DEPTH-1:0] vld;
  logic [TABLE_DEPTH-1:0] ngh;
  logic [CntW-1:0]        ncount;

  // Entry data memory: timestamp, address, latitude, longitude, motion, accuracies.
  logic [31:0] mem_time [TABLE_DEPTH];
  logic [31:0] mem_addr [TABLE_DEPTH];
  logic [63:0] mem_pos  [TABLE_DEPTH];
  logic [47:0] mem_mot  [TABLE_DEPTH];
  logic [31:0] mem_acc  [TABLE_DEPTH];

  logic [1:0]      state;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] chk_idx;
  logic            rd_data_ok;

  logic [1:0]  q_cmd;
  logic [31:0] q_addr, q_ts, q_lat, q_lon, q_acc, q_now;
  logic [15:0] q_alt, q_spd, q_hdg;

  logic [31:0] r_time, r_addr, r_acc;
  logic [63:0] r_pos;
  logic [47:0] r_mot;

  logic            hit, has_free;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic [31:0]     hit_time;
  logic [63:0]     hit_pos;
  logic [47:0]     hit_mot;
  logic [31:0]     hit_acc;

  logic accept;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign stall    = (state != S_IDLE) || !out_free;
  assign accept   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address    <= '0;
      entry_lifetime <= lte_pkg::LifetimeReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lte_pkg::CfgOwnAddress: own_address    <= cfg_data;
        lte_pkg::CfgLifetime:   entry_lifetime <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd <= command; q_addr <= address; q_ts <= timestamp;
      q_lat <= latitude; q_lon <= longitude; q_alt <= altitude;
      q_spd <= speed; q_hdg <= heading; q_acc <= accuracies;
      q_now <= current_time;
    end
  end

  // Registered read port, one entry per cycle.
  always_ff @(posedge clk) begin
    r_time <= mem_time[rd_idx];
    r_addr <= mem_addr[rd_idx];
    r_pos  <= mem_pos[rd_idx];
    r_mot  <= mem_mot[rd_idx];
    r_acc  <= mem_acc[rd_idx];
  end

  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_idx] <= q_ts;
      mem_addr[wr_idx] <= q_addr;
      mem_pos[wr_idx]  <= {q_lat, q_lon};
      mem_mot[wr_idx]  <= {q_alt, q_spd, q_hdg};
      mem_acc[wr_idx]  <= q_acc;
    end
  end

  logic age_hit;
  logic [32:0] age_diff;
  assign age_diff = {1'b0, q_now} - {1'b0, r_time};
  assign age_hit  = !age_diff[32] && (age_diff[31:0] >= {16'd0, entry_lifetime});

  // Write-back decision.
  logic is_add, dup, new_ngh, do_ins;
  assign is_add = (q_cmd == lte_pkg::CmdAddPv) || (q_cmd == lte_pkg::CmdAddBeacon);
  assign dup    = hit && (hit_time == q_ts);
  assign do_ins = !hit && has_free;
  always_comb begin
    if (q_cmd == lte_pkg::CmdAddBeacon) new_ngh = 1'b1;
    else if (hit)                       new_ngh = ngh[hit_idx];
    else                                new_ngh = (q_addr == own_address);
  end
  assign wr_en  = (state == S_WRITE) && is_add && (hit ? !dup : has_free);
  assign wr_idx = hit ? hit_idx : free_idx;

  logic [CntW-1:0] cnt_next;
  always_comb begin
    cnt_next = ncount;
    if (wr_en) begin
      if (hit) cnt_next = ncount - {{(CntW-1){1'b0}}, ngh[hit_idx]}
                          + {{(CntW-1){1'b0}}, new_ngh};
      else     cnt_next = ncount + {{(CntW-1){1'b0}}, new_ngh};
    end
  end

  logic [2:0] st_next;
  logic       nb_next;
  always_comb begin
    st_next = lte_pkg::StAged;
    nb_next = 1'b0;
    unique case (q_cmd)
      lte_pkg::CmdAddPv, lte_pkg::CmdAddBeacon: begin
        if (dup) begin
          st_next = lte_pkg::StDuplicate; nb_next = ngh[hit_idx];
        end else if (hit) begin
          st_next = lte_pkg::StUpdated; nb_next = new_ngh;
        end else if (do_ins) begin
          st_next = lte_pkg::StInserted; nb_next = new_ngh;
        end else begin
          st_next = lte_pkg::StFull;
        end
      end
      lte_pkg::CmdAgeOut: st_next = lte_pkg::StAged;
      lte_pkg::CmdLookup: begin
        st_next = hit ? lte_pkg::StFound : lte_pkg::StMissing;
        nb_next = hit && ngh[hit_idx];
      end
      default: ;
    endcase
  end

  logic [CntW-1:0] cnt_m1;
  assign cnt_m1 = (cnt_next == '0) ? '0 : cnt_next - {{(CntW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld <= '0;
      ngh <= '0;
      ncount <= '0;
      out_valid <= 1'b0;
      rd_idx <= '0;
      rd_data_ok <= 1'b0;
    end else begin
      // The read data of a scan cycle is checked in the cycle after.
      rd_data_ok <= (state == S_SCAN);
      if (state == S_WRITE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            rd_idx <= '0;
            hit <= 1'b0;
            has_free <= 1'b0;
          end
        end
        S_SCAN, S_LAST: begin
          chk_idx <= rd_idx;
          if (state == S_SCAN) begin
            if (rd_idx == IdxW'(TABLE_DEPTH - 1)) state <= S_LAST;
            else rd_idx <= rd_idx + 1'b1;
          end else begin
            state <= S_WRITE;
          end
          if (rd_data_ok) begin
            if (q_cmd == lte_pkg::CmdAgeOut) begin
              if (vld[chk_idx] && age_hit) begin
                vld[chk_idx] <= 1'b0;
                ngh[chk_idx] <= 1'b0;
                ncount <= ncount - {{(CntW-1){1'b0}}, ngh[chk_idx]};
              end
            end else if (vld[chk_idx]) begin
              if (!hit && r_addr == q_addr) begin
                hit <= 1'b1; hit_idx <= chk_idx; hit_time <= r_time;
                hit_pos <= r_pos; hit_mot <= r_mot; hit_acc <= r_acc;
              end
            end else if (!has_free) begin
              has_free <= 1'b1; free_idx <= chk_idx;
            end
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
          if (wr_en) begin
            vld[wr_idx] <= 1'b1;
            ngh[wr_idx] <= new_ngh;
          end
          ncount <= cnt_next;
          status <= st_next;
          is_neighbour <= nb_next;
          neighbour_count <= (cnt_m1 > CntW'(127)) ? 7'd127 : 7'(cnt_m1);
          if (q_cmd == lte_pkg::CmdLookup && hit) begin
            entry_timestamp <= hit_time;
            {entry_latitude, entry_longitude} <= hit_pos;
            {entry_altitude, entry_speed, entry_heading} <= hit_mot;
            entry_accuracies <= hit_acc;
          end else begin
            entry_timestamp <= '0; entry_latitude <= '0; entry_longitude <= '0;
            entry_altitude <= '0; entry_speed <= '0; entry_heading <= '0;
            entry_accuracies <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only produced by the write-back cycle.
  a_out_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WRITE) else $error("result without write-back");
  // Neighbour marks exist only on valid entries.
  a_ngh_valid: assert property (@(posedge clk) disable iff (rst)
    (ngh & ~vld) == '0) else $error("neighbour mark on empty entry");
  // The neighbour counter tracks the marks.
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ncount == CntW'($countones(ngh))) else $error("count mismatch");
  // A request is taken only while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE) else $error("request taken while busy");
`endif
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the location table engine: directed table, a table fill, then random requests.
// Depends on lte_pkg and location_table_engine; predicts each result from its own table copy.
module tb_top;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] ts;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [15:0] alt;
    logic [15:0] spd;
    logic [15:0] hdg;
    logic [31:0] acc;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [2:0]  st;
    logic        nb;
    logic [6:0]  cnt;
    logic [31:0] ts;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [15:0] alt;
    logic [15:0] spd;
    logic [15:0] hdg;
    logic [31:0] acc;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic valid = 0;
  logic stall;
  request_t req = '0;
  logic out_valid;
  logic out_stall = 0;
  answer_t ans;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  location_table_engine i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .stall(stall), .command(req.cmd), .address(req.addr),
    .timestamp(req.ts), .latitude(req.lat), .longitude(req.lon), .altitude(req.alt),
    .speed(req.spd), .heading(req.hdg), .accuracies(req.acc), .current_time(req.now),
    .out_valid(out_valid), .out_stall(out_stall), .status(ans.st), .is_neighbour(ans.nb),
    .neighbour_count(ans.cnt), .entry_timestamp(ans.ts), .entry_latitude(ans.lat),
    .entry_longitude(ans.lon), .entry_altitude(ans.alt), .entry_speed(ans.spd),
    .entry_heading(ans.hdg), .entry_accuracies(ans.acc)
  );

  // Shadow copy of the table.
  logic        tbl_valid [lte_pkg::TableDepth];
  logic        tbl_neigh [lte_pkg::TableDepth];
  request_t    tbl_entry [lte_pkg::TableDepth];
  logic [31:0] own_addr;
  logic [15:0] lifetime;

  answer_t pending_answers[$];
  int errors = 0;
  int table_errors = 0;
  int answers_seen = 0;
  logic hold_start = 0;
  int n_full = 0, n_dup = 0, n_found = 0;

  function automatic answer_t predict_table(request_t r);
    answer_t a;
    int hit;
    int slot;
    int n;
    a = '0;
    hit = -1;
    slot = -1;
    n = 0;
    for (int k = 0; k < lte_pkg::TableDepth; k++) begin
      if (tbl_valid[k] && tbl_entry[k].addr == r.addr && hit < 0) hit = k;
      if (!tbl_valid[k] && slot < 0) slot = k;
    end
    case (r.cmd)
      lte_pkg::CmdAddPv, lte_pkg::CmdAddBeacon: begin
        if (hit >= 0) begin
          if (tbl_entry[hit].ts == r.ts) begin
            a.st = lte_pkg::StDuplicate;
            a.nb = tbl_neigh[hit];
          end else begin
            a.st = lte_pkg::StUpdated;
            a.nb = (r.cmd == lte_pkg::CmdAddBeacon) ? 1'b1 : tbl_neigh[hit];
            tbl_entry[hit] = r;
            tbl_neigh[hit] = a.nb;
          end
        end else if (slot < 0) begin
          a.st = lte_pkg::StFull;
        end else begin
          a.st = lte_pkg::StInserted;
          a.nb = (r.cmd == lte_pkg::CmdAddBeacon) || (r.addr == own_addr);
          tbl_valid[slot] = 1;
          tbl_neigh[slot] = a.nb;
          tbl_entry[slot] = r;
        end
      end
      lte_pkg::CmdAgeOut: begin
        a.st = lte_pkg::StAged;
        for (int k = 0; k < lte_pkg::TableDepth; k++)
          if (tbl_valid[k] && r.now >= tbl_entry[k].ts && r.now - tbl_entry[k].ts >= lifetime)
            tbl_valid[k] = 0;
      end
      default: begin
        if (hit < 0) begin
          a.st = lte_pkg::StMissing;
        end else begin
          a.st = lte_pkg::StFound;
          a.nb = tbl_neigh[hit];
          a.ts = tbl_entry[hit].ts;
          a.lat = tbl_entry[hit].lat;
          a.lon = tbl_entry[hit].lon;
          a.alt = tbl_entry[hit].alt;
          a.spd = tbl_entry[hit].spd;
          a.hdg = tbl_entry[hit].hdg;
          a.acc = tbl_entry[hit].acc;
        end
      end
    endcase
    for (int k = 0; k < lte_pkg::TableDepth; k++) if (tbl_valid[k] && tbl_neigh[k]) n++;
    a.cnt = (n == 0) ? 7'd0 : 7'(n - 1);
    return a;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // Valid stays high after the accepting edge so that back-to-back requests
  // do not need a second assignment in the same step.
  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      valid <= 0;
      wait_cycles(gap);
    end
    req <= r;
    valid <= 1;
    pending_answers = {pending_answers, predict_table(r)};
    @(posedge clk);
    while (stall) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] data);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 0;
    if (idx == lte_pkg::CfgOwnAddress) own_addr = data;
    else lifetime = data[15:0];
    @(posedge clk);
  endtask

  task automatic drain_results();
    valid <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    wait_cycles(2 * lte_pkg::TableDepth + 10);
  endtask

  // Random field content, with a small address pool so that hits are common.
  function automatic request_t random_request(logic [1:0] c, int pool);
    request_t r;
    r.cmd = c;
    r.addr = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, pool));
    r.ts = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom_range(0, 40);
    if ($urandom_range(0, 15) == 0) r.ts = $urandom;
    r.lat = $urandom;
    r.lon = $urandom;
    r.alt = 16'($urandom);
    r.spd = 16'($urandom);
    r.hdg = 16'($urandom);
    r.acc = $urandom;
    r.now = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 50);
    return r;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && !out_stall) begin
      answers_seen <= answers_seen + 1;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, ans);
        errors <= errors + 1;
      end else begin
        exp_a = pending_answers.pop_front();
        if (exp_a.st == lte_pkg::StFull) n_full <= n_full + 1;
        if (exp_a.st == lte_pkg::StDuplicate) n_dup <= n_dup + 1;
        if (exp_a.st == lte_pkg::StFound) n_found <= n_found + 1;
        if (ans !== exp_a) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_a, ans);
          errors <= errors + 1;
        end
      end
    end
  end

  // Receiver stalls: a random wait after each result, and one long hold on request.
  initial begin
    int gap;
    int hold;
    logic held;
    gap = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_start && !held) begin
        hold = 150;
        held = 1;
      end
      if (out_valid && !out_stall) gap = $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1;
        hold = hold - 1;
      end else if (gap > 0) begin
        out_stall <= 1;
        gap = gap - 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  typedef struct {
    request_t r;
    logic     typed;
    answer_t  a;
  } vector_t;

  initial begin
    vector_t vecs[$];
    vector_t v;
    request_t r;
    logic [1:0] c;
    for (int k = 0; k < lte_pkg::TableDepth; k++) begin
      tbl_valid[k] = 0;
      tbl_neigh[k] = 0;
      tbl_entry[k] = '0;
    end
    own_addr = 0;
    lifetime = lte_pkg::LifetimeReset;
    wait_cycles(10);
    rst <= 0;
    @(posedge clk);

    // Directed table: typed answers for the plain cases, predictor for the rest.
    v.typed = 1;
    v.r = '{lte_pkg::CmdLookup, 32'd7, 0, 0, 0, 0, 0, 0, 0, 0};
    v.a = '{lte_pkg::StMissing, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAddPv, 32'd0, 32'd10, '1, '1, '1, '1, '1, '1, 0};
    v.a = '{lte_pkg::StInserted, 1, 0, 0, 0, 0, 0, 0, 0, 0};  // own address at reset is zero
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAddPv, 32'd0, 32'd10, 0, 0, 0, 0, 0, 0, 0};
    v.a = '{lte_pkg::StDuplicate, 1, 0, 0, 0, 0, 0, 0, 0, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdLookup, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0};
    v.a = '{lte_pkg::StFound, 1, 0, 32'd10, '1, '1, '1, '1, '1, '1};
    vecs = {vecs, v};
    v.typed = 0;
    v.r = '{lte_pkg::CmdAddPv, '1, '1, 0, 0, 0, 0, 0, 0, '1};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAddPv, '1, 32'd3, 32'h5a5a5a5a, 32'ha5a5a5a5, 16'h1234, 16'h8000,
            16'h7fff, 32'hdeadbeef, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAddBeacon, '1, 32'd4, 1, 2, 3, 4, 5, 6, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAddBeacon, 32'd9, 32'd0, 1, 2, 3, 4, 5, 6, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdLookup, '1, 0, 0, 0, 0, 0, 0, 0, 0};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAgeOut, 0, 0, 0, 0, 0, 0, 0, 0, 32'd2};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAgeOut, 0, 0, 0, 0, 0, 0, 0, 0, 32'd9};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdAgeOut, 0, 0, 0, 0, 0, 0, 0, 0, '1};
    vecs = {vecs, v};
    v.r = '{lte_pkg::CmdLookup, 32'd9, 0, 0, 0, 0, 0, 0, 0, 0};
    vecs = {vecs, v};
    foreach (vecs[i]) begin
      send_request(vecs[i].r);
      if (vecs[i].typed && pending_answers[$] !== vecs[i].a) begin
        $display("%0t: table row %0d expected %p predicted %p", $time, i, vecs[i].a,
                 pending_answers[$]);
        table_errors++;
      end
    end
    drain_results();

    // Fill the table past its depth while the receiver holds off.
    write_register(lte_pkg::CfgOwnAddress, 32'd1000);
    write_register(lte_pkg::CfgLifetime, 32'hffff);
    hold_start = 1;
    for (int k = 0; k < lte_pkg::TableDepth + 3; k++) begin
      r = random_request(($urandom_range(0, 1) == 0) ? lte_pkg::CmdAddPv
                                                      : lte_pkg::CmdAddBeacon, 0);
      r.addr = 32'd1000 + k;
      send_request(r);
    end
    r = random_request(lte_pkg::CmdAgeOut, 0);
    r.now = '1;
    send_request(r);
    drain_results();

    // Random phases with different settings; the last one has the smallest lifetime.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(lte_pkg::CfgOwnAddress, 32'd3);
          write_register(lte_pkg::CfgLifetime, 32'd5);
        end
        1: begin
          write_register(lte_pkg::CfgOwnAddress, '1);
          write_register(lte_pkg::CfgLifetime, 32'd20);
        end
        2: begin
          write_register(lte_pkg::CfgOwnAddress, 32'd0);
          write_register(lte_pkg::CfgLifetime, 32'hffff);
        end
        default: begin
          write_register(lte_pkg::CfgOwnAddress, $urandom);
          write_register(lte_pkg::CfgLifetime, 32'd1);
        end
      endcase
      for (int i = 0; i < 300; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: c = lte_pkg::CmdAddPv;
          3, 4, 5: c = lte_pkg::CmdAddBeacon;
          6:       c = lte_pkg::CmdAgeOut;
          default: c = lte_pkg::CmdLookup;
        endcase
        r = random_request(c, (phase == 2) ? 90 : 40);
        send_request(r);
        // The sender stops once per phase until all results are back.
        if (i == 150) begin
          valid <= 0;
          while (pending_answers.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end

    $display("Covered %0d results: %0d full drops, %0d duplicates, %0d lookups found.",
             answers_seen, n_full, n_dup, n_found);
    if (errors == 0 && table_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
